// File: src/spoam_pkg.sv
// spoam_pkg: shared constants, types and the spacer oligo table for the
// spacer oligo approximate matcher. No dependencies; used by every module in src.
`default_nettype none
package spoam_pkg;

  localparam int NUM_SPACERS    = 43;
  localparam int SPACER_LEN     = 25;
  localparam int COUNT_BITS_DEF = 24;
  localparam int MM_W           = 3;
  localparam int MC_W           = 24;
  localparam int BASE_W         = 3;
  localparam int SNUM_W         = 6;
  localparam int IDX_W          = $clog2(NUM_SPACERS);
  localparam int BIR_W          = $clog2(SPACER_LEN + 1);
  localparam int CIDX_W         = 2;
  localparam int CDATA_W        = 24;

  localparam logic [BASE_W-1:0] CODE_OTHER = 3'd4;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MAX_MISMATCH = 2'd0,
    CFG_MIN_COUNT    = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    KIND_BASE   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BASE_W-1:0] base;
    logic              eor;
  } item_t;

  localparam logic [8*SPACER_LEN-1:0] OLIGO_TXT [NUM_SPACERS] = '{
    "ATAGAGGGTCGCCGGCTCTGGATCA", "CCTCATGCTTGGGCGACAGCTTTTG",
    "CCGTGCTTCCAGTGATCGCCTTCTA", "ACGTCATACGCCGACCAATCATCAG",
    "TTTTCTGACCACTTGTGCGGGATTA", "CGTCGTCATTTCCGGCTTCAATTTC",
    "GAGGAGAGCGAGTACTCGGGGCTGC", "CGTGAAACCGCCCCCAGCCTCGCCG",
    "ACTCGGAATCCCATGTGCTGACAGC", "TCGACACCCGCTCTAGTTGACTTCC",
    "GTGAGCAACGGCGGCGGCAACCTGG", "ATATCTGCTGCCCGCCCGGGGAGAT",
    "GACCATCATTGCCATTCCCTCTCCC", "GGTGTGATGCGGATGGTCGGCTCGG",
    "CTTGAATAACGCGCAGTGAATTTCG", "CGAGTTCCCGTCAGCGTCGTAAATC",
    "GCGCCGGCCCGCGCGGATGACTCCG", "CATGGACCCGGGCGAGCTGCAGATG",
    "TAACTGGCTTGGCGCTGATCCTGGT", "TTGACCTCGCCAGGAGAGAAGATCA",
    "TCGATGTCGATGTCCCAATCGTCGA", "ACCGCAGACGGCACGATTGAGACAA",
    "AGCATCGCTGATGCGGTCCAGCTCG", "CCGCCTGCTGGGTGAGACGTGCTCG",
    "GATCAGCGACCACCGCACCCTGTCA", "CTTCAGCACCACCATCATCCGGCGC",
    "GGATTCGTGATCTCTTCCCGCGGAT", "TGCCCCGGCGTTTAGCGATCACAAC",
    "AAATACAGGCTCCACGACACGACCA", "GGTTGCCCCGCGCCCTTTTCCAGCC",
    "TCAGACAGGTTCGCGTCGATCAAGT", "GACCAAATAGGTATCGGCGTGTTCA",
    "GACATGACGGCGGTGCCGCACTTGA", "AAGTCACCTCGCCCACACCGTCGAA",
    "TCCGTACGCTCGAAACGCTTCCAAC", "CGAAATCCAGCACCACATCCGCAGC",
    "CGCGAACTCGTCCACAGTCCCCCTT", "CGTGGATGGCGGATGCGTTGTGCGC",
    "GACGATGGCCAGTAAATCGGCGTGG", "CGCCATCTGTGCCTCATACAGGTCC",
    "GGAGCTTTCCGGCTTCTATCAGGTA", "ATGGTGGGACATGGACGAGCGCGAC",
    "CGCAGAATCGCACCGGGTGCGGGAG"
  };

  // base code of oligo s at position k, leftmost letter is position 0
  function automatic logic [BASE_W-1:0] oligo_code(input int s, input int k);
    logic [7:0] c;
    c = OLIGO_TXT[s][8*(SPACER_LEN-1-k) +: 8];
    unique case (c)
      8'h41:   oligo_code = 3'd0;
      8'h43:   oligo_code = 3'd1;
      8'h47:   oligo_code = 3'd2;
      8'h54:   oligo_code = 3'd3;
      default: oligo_code = CODE_OTHER;
    endcase
  endfunction

  // reverse complement of oligo s at position k
  function automatic logic [BASE_W-1:0] revcomp_code(input int s, input int k);
    logic [BASE_W-1:0] r;
    r = oligo_code(s, SPACER_LEN - 1 - k);
    revcomp_code = r[2] ? CODE_OTHER : {1'b0, ~r[1:0]};
  endfunction

endpackage
`default_nettype wire

// File: src/spoam_front.sv
// spoam_front: input word acceptance, classification into base or report
// items and a two-entry queue towards the back end. Depends on spoam_pkg.
`default_nettype none
module spoam_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,  // [2:0] base
  input  wire logic               in_tuser,  // [0] mode
  input  wire logic               in_tlast,  // end of read
  output spoam_pkg::item_t        head,
  output logic                    head_vld,
  input  wire logic               head_rdy
);

  spoam_pkg::item_t q_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push, pop;
  spoam_pkg::item_t item_in;

  always_comb begin
    item_in.kind = in_tuser ? spoam_pkg::KIND_REPORT : spoam_pkg::KIND_BASE;
    item_in.base = in_tdata[spoam_pkg::BASE_W-1:0];
    item_in.eor  = in_tlast;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign head_vld  = (cnt_r != 2'd0);
  assign head      = q_r[rd_ptr_r];
  assign pop       = head_vld && head_rdy;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// File: src/spoam_cmp.sv
// spoam_cmp: one lane per spacer comparing the window with the oligo and its
// reverse complement by Hamming distance. Depends on spoam_pkg.
`default_nettype none
module spoam_cmp (
  input  wire logic [spoam_pkg::BASE_W-1:0] win [spoam_pkg::SPACER_LEN],
  input  wire logic [spoam_pkg::MM_W-1:0]   max_mm,
  output logic [spoam_pkg::NUM_SPACERS-1:0] match
);

  for (genvar s = 0; s < spoam_pkg::NUM_SPACERS; s++) begin : g_lane
    logic [spoam_pkg::SPACER_LEN-1:0] fwd_miss, rev_miss;
    logic [spoam_pkg::BASE_W-1:0]     f, r;

    always_comb begin
      for (int k = 0; k < spoam_pkg::SPACER_LEN; k++) begin
        f = spoam_pkg::oligo_code(s, k);
        r = spoam_pkg::revcomp_code(s, k);
        // other codes never match anything
        fwd_miss[k] = win[k][2] || f[2] || (win[k][1:0] != f[1:0]);
        rev_miss[k] = win[k][2] || r[2] || (win[k][1:0] != r[1:0]);
      end
    end

    assign match[s] = ($countones(fwd_miss) <= int'(max_mm)) ||
                      ($countones(rev_miss) <= int'(max_mm));
  end

endmodule
`default_nettype wire

// File: src/spoam_back.sv
// spoam_back: sliding window, per-read found flags, per-spacer count ring and
// the report sequencer with its output register. Depends on spoam_pkg, spoam_cmp.
`default_nettype none
module spoam_back #(
  parameter int COUNT_BITS = spoam_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire spoam_pkg::item_t           head,
  input  wire logic                       head_vld,
  output logic                            head_rdy,
  input  wire logic [spoam_pkg::MM_W-1:0] max_mm,
  input  wire logic [spoam_pkg::MC_W-1:0] min_cnt,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [((spoam_pkg::SNUM_W+COUNT_BITS+1+7)/8)*8-1:0] out_tdata,
  output logic                            out_tlast
);

  localparam int N    = spoam_pkg::NUM_SPACERS;
  localparam int L    = spoam_pkg::SPACER_LEN;
  localparam int TD_W = ((spoam_pkg::SNUM_W + COUNT_BITS + 1 + 7) / 8) * 8;
  localparam int CW   = (COUNT_BITS > spoam_pkg::MC_W) ? COUNT_BITS : spoam_pkg::MC_W;

  logic [spoam_pkg::BASE_W-1:0]  win_r [L];
  logic [spoam_pkg::BIR_W-1:0]   bir_r, bir_inc;
  logic                          cmp_vld_r, eor_q_r, stage_busy;
  logic [N-1:0]                  found_r, found_all, match;
  logic [COUNT_BITS-1:0]         cnt_r [N];
  logic                          rpt_active_r;
  logic [spoam_pkg::IDX_W-1:0]   idx_r;
  logic                          ov_r, load, pop, last_idx, pres;
  logic [spoam_pkg::SNUM_W-1:0]  onum_r;
  logic [COUNT_BITS-1:0]         ocnt_r;
  logic                          opres_r, olast_r;

  spoam_cmp u_cmp (
    .win    (win_r),
    .max_mm (max_mm),
    .match  (match)
  );

  assign stage_busy = cmp_vld_r || eor_q_r;
  // a report waits until the last base's compare has landed in the counts
  assign head_rdy   = !rpt_active_r && (head.kind == spoam_pkg::KIND_BASE || !stage_busy);
  assign pop        = head_vld && head_rdy;
  assign load       = rpt_active_r && (!ov_r || out_tready);
  assign last_idx   = (idx_r == spoam_pkg::IDX_W'(N - 1));
  assign bir_inc    = (bir_r < spoam_pkg::BIR_W'(L)) ? bir_r + 1'b1 : bir_r;
  assign found_all  = found_r | (cmp_vld_r ? match : '0);
  assign pres       = (max_mm == '0) ? (CW'(cnt_r[0]) >= CW'(min_cnt)) : (cnt_r[0] != '0);

  always_ff @(posedge clk) begin
    if (load) begin
      onum_r  <= spoam_pkg::SNUM_W'(idx_r) + 1'b1;
      ocnt_r  <= cnt_r[0];
      opres_r <= pres;
      olast_r <= last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) win_r[k] <= spoam_pkg::CODE_OTHER;
      for (int s = 0; s < N; s++) cnt_r[s] <= '0;
      bir_r        <= '0;
      cmp_vld_r    <= 1'b0;
      eor_q_r      <= 1'b0;
      found_r      <= '0;
      rpt_active_r <= 1'b0;
      idx_r        <= '0;
      ov_r         <= 1'b0;
    end else begin
      cmp_vld_r <= 1'b0;
      eor_q_r   <= 1'b0;
      if (pop && head.kind == spoam_pkg::KIND_BASE) begin
        for (int k = 0; k < L - 1; k++) win_r[k] <= win_r[k+1];
        win_r[L-1] <= head.base;
        bir_r      <= head.eor ? '0 : bir_inc;
        cmp_vld_r  <= (bir_inc >= spoam_pkg::BIR_W'(L));
        eor_q_r    <= head.eor;
      end
      if (pop && head.kind == spoam_pkg::KIND_REPORT) begin
        rpt_active_r <= 1'b1;
        idx_r        <= '0;
      end

      // compare stage result folds into the read's found flags
      found_r <= eor_q_r ? '0 : found_all;

      priority if (load) begin
        // count ring rotates out through entry 0, refilling with zero
        for (int s = 0; s < N - 1; s++) cnt_r[s] <= cnt_r[s+1];
        cnt_r[N-1] <= '0;
        idx_r      <= idx_r + 1'b1;
        if (last_idx) rpt_active_r <= 1'b0;
      end else if (eor_q_r) begin
        for (int s = 0; s < N; s++) begin
          if (found_all[s] && cnt_r[s] != '1) cnt_r[s] <= cnt_r[s] + 1'b1;
        end
      end else begin
      end

      if (load)            ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = TD_W'({opres_r, ocnt_r, onum_r});
  assign out_tlast  = olast_r;

  a_no_stage_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    rpt_active_r |-> !stage_busy)
    else $error("compare stage busy during report");

  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_idx) |=> !rpt_active_r && out_tlast)
    else $error("report did not end on last spacer");

  a_found_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    eor_q_r |=> found_r == '0)
    else $error("found flags survive end of read");

  a_ring_refill: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r[N-1] == '0)
    else $error("count ring not refilled with zero");

endmodule
`default_nettype wire

// File: src/spacer_oligo_approx_matcher.sv
// spacer_oligo_approx_matcher: top level with configuration registers,
// front queue and back end. Depends on spoam_pkg, spoam_front, spoam_back.
//
// Input channel in_*: one word per base (in_tuser=0, base in in_tdata[2:0],
// in_tlast on the last base of a read) or a report request (in_tuser=1).
// Base words are taken one per cycle while the front buffer has room and
// produce no output; every full 25-base window is matched against all 43
// spacers and their reverse complements by parallel combinational lanes.
// A report word yields 43 output words, one per cycle when out_tready is
// held, each through the output register; a report is accepted only once
// the last base's compare has landed in the counts, and out_tlast marks the
// last spacer. The count ring shifts out one spacer per cycle while
// out_tready is high; while a report runs, bases queue in the two-entry
// front buffer and in_tready drops once it is full.
// When out_tready is low the output word holds and the back end stalls;
// the input keeps filling the front buffer.
// Configuration: cfg_index 0 max_mismatch, 1 presence threshold; always
// ready, write only while idle. Reset clears counts, read state and the
// window (all other), and sets max_mismatch 0 and the threshold to 2.
`default_nettype none
module spacer_oligo_approx_matcher #(
  parameter int COUNT_BITS = spoam_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,  // [2:0] base
  input  wire logic                          in_tuser,  // [0] mode
  input  wire logic                          in_tlast,  // end_of_read
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [5:0] spacer_number, then read_count, then present, zero pad
  output logic [((spoam_pkg::SNUM_W+COUNT_BITS+1+7)/8)*8-1:0] out_tdata,
  output logic                               out_tlast,  // last
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [spoam_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [spoam_pkg::CDATA_W-1:0] cfg_data
);

  logic [spoam_pkg::MM_W-1:0] max_mm_r;
  logic [spoam_pkg::MC_W-1:0] min_cnt_r;
  spoam_pkg::item_t           head;
  logic                       head_vld, head_rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mm_r  <= '0;
      min_cnt_r <= spoam_pkg::MC_W'(2);
    end else if (cfg_valid) begin
      if (cfg_index == spoam_pkg::CFG_MAX_MISMATCH) max_mm_r  <= cfg_data[spoam_pkg::MM_W-1:0];
      if (cfg_index == spoam_pkg::CFG_MIN_COUNT)    min_cnt_r <= cfg_data[spoam_pkg::MC_W-1:0];
    end
  end

  spoam_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .head      (head),
    .head_vld  (head_vld),
    .head_rdy  (head_rdy)
  );

  spoam_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_vld   (head_vld),
    .head_rdy   (head_rdy),
    .max_mm     (max_mm_r),
    .min_cnt    (min_cnt_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
